// File: design/gn1d_pkg.sv
// ----------------------------------------------------------------------------
// gn1d_pkg: shared types and constants for the 1-D gradient noise block
// Operation codes, the pipeline tag and the power-on permutation table.
// ----------------------------------------------------------------------------
package gn1d_pkg;

  localparam logic [1:0] OP_NOISE = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // travels with every item down the pipeline
  typedef struct packed {
    logic       vld;
    logic [1:0] op;
  } gn1d_tag_t;

  localparam int PERM_INIT_DEPTH = 256;

  localparam logic [7:0] PERM_INIT [PERM_INIT_DEPTH] = '{
    8'd170, 8'd22,  8'd164, 8'd57,  8'd210, 8'd206, 8'd153, 8'd48,
    8'd0,   8'd85,  8'd196, 8'd216, 8'd60,  8'd165, 8'd255, 8'd157,
    8'd107, 8'd21,  8'd73,  8'd72,  8'd36,  8'd140, 8'd247, 8'd66,
    8'd176, 8'd71,  8'd31,  8'd79,  8'd75,  8'd6,   8'd200, 8'd253,
    8'd7,   8'd180, 8'd112, 8'd9,   8'd251, 8'd131, 8'd235, 8'd209,
    8'd27,  8'd241, 8'd240, 8'd87,  8'd207, 8'd23,  8'd17,  8'd70,
    8'd81,  8'd249, 8'd191, 8'd194, 8'd230, 8'd88,  8'd25,  8'd76,
    8'd129, 8'd203, 8'd97,  8'd108, 8'd135, 8'd173, 8'd26,  8'd219,
    8'd227, 8'd37,  8'd116, 8'd58,  8'd47,  8'd133, 8'd181, 8'd74,
    8'd14,  8'd8,   8'd205, 8'd103, 8'd94,  8'd62,  8'd218, 8'd113,
    8'd214, 8'd65,  8'd128, 8'd144, 8'd134, 8'd120, 8'd3,   8'd80,
    8'd184, 8'd121, 8'd67,  8'd160, 8'd187, 8'd19,  8'd189, 8'd30,
    8'd122, 8'd237, 8'd143, 8'd51,  8'd69,  8'd49,  8'd231, 8'd174,
    8'd54,  8'd211, 8'd177, 8'd18,  8'd4,   8'd179, 8'd197, 8'd20,
    8'd126, 8'd150, 8'd228, 8'd59,  8'd83,  8'd186, 8'd11,  8'd234,
    8'd119, 8'd145, 8'd63,  8'd84,  8'd115, 8'd220, 8'd5,   8'd193,
    8'd239, 8'd96,  8'd24,  8'd159, 8'd225, 8'd33,  8'd147, 8'd105,
    8'd171, 8'd202, 8'd155, 8'd183, 8'd61,  8'd238, 8'd198, 8'd142,
    8'd213, 8'd100, 8'd35,  8'd93,  8'd204, 8'd124, 8'd222, 8'd223,
    8'd162, 8'd101, 8'd39,  8'd92,  8'd141, 8'd68,  8'd190, 8'd64,
    8'd169, 8'd41,  8'd244, 8'd117, 8'd90,  8'd137, 8'd167, 8'd236,
    8'd243, 8'd172, 8'd32,  8'd217, 8'd86,  8'd151, 8'd99,  8'd229,
    8'd226, 8'd34,  8'd44,  8'd182, 8'd10,  8'd1,   8'd52,  8'd102,
    8'd139, 8'd16,  8'd110, 8'd245, 8'd118, 8'd208, 8'd252, 8'd201,
    8'd114, 8'd233, 8'd242, 8'd248, 8'd175, 8'd250, 8'd215, 8'd156,
    8'd12,  8'd246, 8'd132, 8'd254, 8'd192, 8'd42,  8'd91,  8'd28,
    8'd95,  8'd106, 8'd152, 8'd125, 8'd199, 8'd98,  8'd89,  8'd50,
    8'd163, 8'd43,  8'd148, 8'd123, 8'd149, 8'd109, 8'd45,  8'd46,
    8'd136, 8'd161, 8'd195, 8'd78,  8'd111, 8'd127, 8'd2,   8'd77,
    8'd154, 8'd168, 8'd221, 8'd146, 8'd232, 8'd224, 8'd178, 8'd188,
    8'd130, 8'd138, 8'd104, 8'd166, 8'd40,  8'd55,  8'd158, 8'd56,
    8'd82,  8'd13,  8'd185, 8'd29,  8'd38,  8'd212, 8'd15,  8'd53
  };

endpackage

// File: design/gn1d_wrap.sv
// ----------------------------------------------------------------------------
// gn1d_wrap: table index generation
// Three-stage reduction of the cell (or table index) modulo the table size
// by reciprocal multiply and one correction step.
// ----------------------------------------------------------------------------
module gn1d_wrap
  import gn1d_pkg::*;
#(
  parameter int TABLE_SIZE = 256,
  parameter int FRAC_BITS  = 16,
  localparam int IW = $clog2(TABLE_SIZE)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  gn1d_tag_t            tag_i,
  input  logic [31:0]          position_i,
  input  logic [7:0]           index_i,
  input  logic [7:0]           value_i,
  output gn1d_tag_t            tag_o,
  output logic [IW-1:0]        idx0_o,
  output logic [IW-1:0]        idx1_o,
  output logic [FRAC_BITS-1:0] frac_o,
  output logic [7:0]           value_o
);

  localparam int CW = 32 - FRAC_BITS;
  localparam int SH = CW + IW;
  localparam int RW = (CW > IW + 1) ? CW : IW + 1;
  localparam longint unsigned RECIP = (64'd1 << SH) / TABLE_SIZE;
  localparam logic [CW:0] RECIP_C = (CW + 1)'(RECIP);
  localparam logic [IW:0] TSZ_C = (IW + 1)'(TABLE_SIZE);
  // cell is biased by 2^(CW-1) to make it non-negative; this undoes it
  localparam int OFF = int'((64'd1 << (CW - 1)) % TABLE_SIZE);

  gn1d_tag_t            tag1_r, tag2_r, tag3_r;
  logic [CW-1:0]        x1_r, x2_r, x3_r;
  logic [CW-1:0]        q2_r, qt3_r;
  logic [FRAC_BITS-1:0] f1_r, f2_r, f3_r;
  logic [7:0]           val1_r, val2_r, val3_r;

  logic [CW-1:0]   x_nxt;
  logic [2*CW:0]   q_prod;
  logic [CW+IW:0]  qt_prod;
  logic [RW-1:0]   rem;
  logic [RW-1:0]   rem_red;
  logic [IW-1:0]   rmod;
  logic [IW:0]     rmod_wrap;
  logic [IW-1:0]   i0;

  // offset-binary cell for queries, plain index for table access
  assign x_nxt = (tag_i.op == OP_NOISE) ? {~position_i[31], position_i[30:FRAC_BITS]}
                                        : CW'(index_i);

  assign q_prod  = x1_r * RECIP_C;
  assign qt_prod = q2_r * TSZ_C;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
    end else if (en) begin
      tag1_r <= tag_i;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r   <= x_nxt;
      f1_r   <= position_i[FRAC_BITS-1:0];
      val1_r <= value_i;
      x2_r   <= x1_r;
      q2_r   <= CW'(q_prod >> SH);
      f2_r   <= f1_r;
      val2_r <= val1_r;
      x3_r   <= x2_r;
      qt3_r  <= CW'(qt_prod);
      f3_r   <= f2_r;
      val3_r <= val2_r;
    end
  end

  // quotient may be low by one: remainder lies in [0, 2*TABLE_SIZE)
  always_comb begin
    rem       = RW'(x3_r) - RW'(qt3_r);
    rem_red   = (rem >= RW'(TABLE_SIZE)) ? rem - RW'(TABLE_SIZE) : rem;
    rmod      = IW'(rem_red);
    rmod_wrap = {1'b0, rmod} + (IW + 1)'(TABLE_SIZE - OFF);
    if (tag3_r.op != OP_NOISE) begin
      i0 = rmod;
    end else if (rmod >= IW'(OFF)) begin
      i0 = rmod - IW'(OFF);
    end else begin
      i0 = IW'(rmod_wrap);
    end
  end

  assign idx0_o  = i0;
  assign idx1_o  = (i0 == IW'(TABLE_SIZE - 1)) ? '0 : i0 + IW'(1);
  assign tag_o   = tag3_r;
  assign frac_o  = f3_r;
  assign value_o = val3_r;

endmodule

// File: design/gn1d_table.sv
// ----------------------------------------------------------------------------
// gn1d_table: permutation table memory
// One write port, two registered read ports; fills itself from the
// power-on permutation after reset.
// ----------------------------------------------------------------------------
module gn1d_table
  import gn1d_pkg::*;
#(
  parameter int TABLE_SIZE = 256,
  localparam int IW = $clog2(TABLE_SIZE)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic [IW-1:0] rd_idx0,
  input  logic [IW-1:0] rd_idx1,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_idx,
  input  logic [7:0]    wr_data,
  output logic [7:0]    rd_data0,
  output logic [7:0]    rd_data1,
  output logic          busy
);

  logic [7:0]    perm_r [TABLE_SIZE];
  logic [7:0]    rd0_r, rd1_r;
  logic          fill_r, fill_nxt;
  logic [IW-1:0] fill_cnt_r, fill_cnt_nxt;

  logic          we;
  logic [IW-1:0] wa;
  logic [7:0]    wd;

  always_comb begin
    fill_nxt     = fill_r;
    fill_cnt_nxt = fill_cnt_r;
    if (fill_r) begin
      fill_cnt_nxt = fill_cnt_r + IW'(1);
      if (fill_cnt_r == IW'(TABLE_SIZE - 1)) begin
        fill_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= 1'b1;
      fill_cnt_r <= '0;
    end else begin
      fill_r     <= fill_nxt;
      fill_cnt_r <= fill_cnt_nxt;
    end
  end

  // fill sweep owns the write port until done
  assign we = fill_r | wr_en;
  assign wa = fill_r ? fill_cnt_r : wr_idx;
  assign wd = fill_r ? PERM_INIT[8'(fill_cnt_r)] : wr_data;

  always_ff @(posedge clk) begin
    if (we) begin
      perm_r[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd0_r <= perm_r[rd_idx0];
      rd1_r <= perm_r[rd_idx1];
    end
  end

  assign rd_data0 = rd0_r;
  assign rd_data1 = rd1_r;
  assign busy     = fill_r;

endmodule

// File: design/gn1d_fade.sv
// ----------------------------------------------------------------------------
// gn1d_fade: gradient, quintic fade and interpolation datapath
// Five register stages, one multiplier level per stage, floor rounding.
// ----------------------------------------------------------------------------
module gn1d_fade
  import gn1d_pkg::*;
#(
  parameter int TABLE_SIZE = 256,
  parameter int FRAC_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  gn1d_tag_t            tag_i,
  input  logic [FRAC_BITS-1:0] frac_i,
  input  logic [7:0]           ent0_i,
  input  logic [7:0]           ent1_i,
  output logic                 res_vld_o,
  output logic [17:0]          noise_o,
  output logic [7:0]           entry_o
);

  localparam int F   = FRAC_BITS;
  localparam int SHL = (F < 16) ? 16 - F : 0;
  localparam int SHR = (F > 16) ? F - 16 : 0;
  localparam logic signed [F+4:0]  C15   = (F + 5)'(15 * (1 << F));
  localparam logic signed [F+4:0]  C10   = (F + 5)'(10 * (1 << F));
  localparam logic signed [F+1:0]  ONE_A = (F + 2)'(1 << F);
  localparam logic signed [2*F+5:0] ONE_W = (2 * F + 6)'(1 << F);
  localparam logic signed [F+20:0] SAT_P = (F + 21)'(65536);
  localparam logic signed [F+20:0] SAT_N = -(F + 21)'(65536);

  gn1d_tag_t tag4_r, tag5_r, tag6_r, tag7_r, tag8_r;

  logic [F-1:0]          f4_r, f5_r;
  logic [7:0]            ent5_r, ent6_r, ent7_r, ent8_r;
  logic signed [F+4:0]   fu5_r;
  logic [F-1:0]          ff5_r;
  logic signed [F+1:0]   a5_r, a6_r, a7_r, a8_r;
  logic signed [F+2:0]   d5_r, d6_r, d7_r;
  logic [F-1:0]          c6_r;
  logic signed [F+4:0]   v6_r;
  logic [F:0]            fd7_r;
  logic signed [F+2:0]   m8_r;

  // stage 4 (table data arrives)
  logic signed [F+4:0]   f_s, u;
  logic signed [2*F+9:0] fu_p;
  logic [2*F-1:0]        ff_p;
  logic signed [F+1:0]   fa, a, b;
  logic signed [F+2:0]   d;
  logic                  g0, g1;
  // later stages
  logic [2*F-1:0]        c_p;
  logic signed [F+4:0]   v;
  logic signed [2*F+5:0] fd_p, fd_sh;
  logic [F:0]            fd;
  logic signed [2*F+4:0] m_p;
  logic signed [F+3:0]   r;
  logic signed [F+20:0]  rw, rs;
  logic [17:0]           sat;

  assign f_s  = signed'({5'b0, f4_r});
  assign u    = (f_s <<< 2) + (f_s <<< 1) - C15;
  assign fu_p = f_s * u;
  assign ff_p = f4_r * f4_r;

  // entry above half the table size: gradient +1, else -1
  assign g0 = (int'(ent0_i) * 2) > TABLE_SIZE;
  assign g1 = (int'(ent1_i) * 2) > TABLE_SIZE;
  assign fa = signed'({2'b0, f4_r});
  assign a  = g0 ? fa : -fa;
  assign b  = g1 ? fa - ONE_A : ONE_A - fa;
  assign d  = (F + 3)'(b) - (F + 3)'(a);

  assign c_p = ff5_r * f5_r;
  assign v   = fu5_r + C10;

  assign fd_p  = signed'({1'b0, c6_r}) * v6_r;
  assign fd_sh = fd_p >>> F;
  always_comb begin
    if (fd_sh < 0) begin
      fd = '0;
    end else if (fd_sh > ONE_W) begin
      fd = (F + 1)'(1 << F);
    end else begin
      fd = (F + 1)'(fd_sh);
    end
  end

  assign m_p = signed'({1'b0, fd7_r}) * d7_r;

  // final sum, rescale to 16 fraction bits, saturate
  assign r  = (F + 4)'(a8_r) + (F + 4)'(m8_r);
  assign rw = (F + 21)'(r);
  assign rs = (rw <<< SHL) >>> SHR;
  always_comb begin
    if (rs > SAT_P) begin
      sat = 18'(SAT_P);
    end else if (rs < SAT_N) begin
      sat = 18'(SAT_N);
    end else begin
      sat = 18'(rs);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag4_r <= '0;
      tag5_r <= '0;
      tag6_r <= '0;
      tag7_r <= '0;
      tag8_r <= '0;
    end else if (en) begin
      tag4_r <= tag_i;
      tag5_r <= tag4_r;
      tag6_r <= tag5_r;
      tag7_r <= tag6_r;
      tag8_r <= tag7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f4_r   <= frac_i;
      f5_r   <= f4_r;
      ent5_r <= ent0_i;
      fu5_r  <= (F + 5)'(fu_p >>> F);
      ff5_r  <= F'(ff_p >> F);
      a5_r   <= a;
      d5_r   <= d;
      ent6_r <= ent5_r;
      c6_r   <= F'(c_p >> F);
      v6_r   <= v;
      a6_r   <= a5_r;
      d6_r   <= d5_r;
      ent7_r <= ent6_r;
      fd7_r  <= fd;
      a7_r   <= a6_r;
      d7_r   <= d6_r;
      ent8_r <= ent7_r;
      m8_r   <= (F + 3)'(m_p >>> F);
      a8_r   <= a7_r;
    end
  end

  assign res_vld_o = tag8_r.vld && (tag8_r.op == OP_NOISE || tag8_r.op == OP_READ);
  assign noise_o   = (tag8_r.op == OP_NOISE) ? sat : '0;
  assign entry_o   = (tag8_r.op == OP_READ) ? ent8_r : '0;

endmodule

// File: design/gradient_noise_1d.sv
// Throughput: one item per cycle while in_stall is low; the table's two read ports serve both
//   cells of a query in the same access, so nothing recirculates.
// Reset: synchronous, active low. The table then refills from the fixed
//   permutation, one entry per cycle, with in_stall high until the fill is done.
// ----------------------------------------------------------------------------
// gradient_noise_1d: one-dimensional gradient noise
// Signed Q16.16 position in, signed Q1.16 noise out; the permutation table
// can be written and read back through the same item channel.
// ----------------------------------------------------------------------------
module gradient_noise_1d
  import gn1d_pkg::*;
#(
  parameter int TABLE_SIZE = 256,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic signed [31:0] in_position,
  input  logic [7:0]         in_table_index,
  input  logic [7:0]         in_table_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [17:0] out_noise_value,
  output logic [7:0]         out_entry_value
);

  localparam int IW = $clog2(TABLE_SIZE);

  // Pipeline map (one stage per cycle, all frozen together on a stall):
  //   1..3  cell / index reduced modulo TABLE_SIZE (gn1d_wrap)
  //   4     table read at cell and cell+1, or table write (gn1d_table)
  //   5..8  gradients, fade polynomial, interpolation (gn1d_fade)
  //   out   output register
  // Writes land in stage 4 in item order and a later item reads the table
  // no earlier than the following edge, so no forwarding is needed.

  gn1d_tag_t            tag_in, tag3;
  logic                 adv;
  logic                 accept;
  logic [IW-1:0]        idx0, idx1;
  logic [FRAC_BITS-1:0] frac3;
  logic [7:0]           val3;
  logic [7:0]           ent0, ent1;
  logic                 tbl_busy;
  logic                 tbl_we;
  logic                 res_vld;
  logic [17:0]          res_noise;
  logic [7:0]           res_entry;

  logic               out_valid_r, out_valid_nxt;
  logic signed [17:0] out_noise_r;
  logic [7:0]         out_entry_r;

  // whole pipeline moves whenever the output register can take a result
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = tbl_busy || !adv;
  assign accept   = in_valid && !in_stall;

  assign tag_in.vld = accept;
  assign tag_in.op  = in_operation;

  gn1d_wrap #(
    .TABLE_SIZE (TABLE_SIZE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_wrap (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .tag_i      (tag_in),
    .position_i (in_position),
    .index_i    (in_table_index),
    .value_i    (in_table_value),
    .tag_o      (tag3),
    .idx0_o     (idx0),
    .idx1_o     (idx1),
    .frac_o     (frac3),
    .value_o    (val3)
  );

  // index reduction already wrapped table_index for writes
  assign tbl_we = adv && tag3.vld && (tag3.op == OP_WRITE);

  gn1d_table #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .rd_idx0  (idx0),
    .rd_idx1  (idx1),
    .wr_en    (tbl_we),
    .wr_idx   (idx0),
    .wr_data  (val3),
    .rd_data0 (ent0),
    .rd_data1 (ent1),
    .busy     (tbl_busy)
  );

  gn1d_fade #(
    .TABLE_SIZE (TABLE_SIZE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_fade (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .tag_i     (tag3),
    .frac_i    (frac3),
    .ent0_i    (ent0),
    .ent1_i    (ent1),
    .res_vld_o (res_vld),
    .noise_o   (res_noise),
    .entry_o   (res_entry)
  );

  // output register; writes and unknown operations leave a bubble here
  assign out_valid_nxt = adv ? res_vld : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_vld) begin
      out_noise_r <= signed'(res_noise);
      out_entry_r <= res_entry;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_noise_r;
  assign out_entry_value = out_entry_r;

`ifndef ASSERT_OFF
  // table is private to the fill sweep until it finishes
  a_no_write_in_fill : assert property (@(posedge clk) disable iff (!rst_n)
    tbl_busy |-> !tbl_we)
    else $error("table write during fill sweep");

  // reduced addresses must land inside the table
  a_idx_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    tag3.vld |-> (int'(idx0) < TABLE_SIZE) && (int'(idx1) < TABLE_SIZE))
    else $error("table address out of range");

  // a result carries either a noise value or a table entry, never both
  a_one_payload : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_noise_value != '0)) |-> (out_entry_value == '0))
    else $error("noise and entry both nonzero");
`endif

endmodule
